FILE: rtl/qxmm_pkg.sv
`timescale 1ns / 1ps
// shared widths, register indexes and test request codes for the quad-x mixer
// no dependencies

package qxmm_pkg;

    // payload widths
    localparam int CMD_W      = 16;
    localparam int TIME_W     = 32;
    localparam int RAW_W      = 11;
    localparam int LEVEL_W    = 15;
    localparam int REQ_W      = 2;
    localparam int SLOT_W     = 2;
    localparam int MOTOR_CNT  = 4;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // default fraction bits of the command format
    localparam int FRAC_BITS_DEF = 14;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RAW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RAW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEST_REQ    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEST_MOTOR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TEST_LEVEL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TEST_DUR    = 3'd6;

    // test request codes
    localparam logic [REQ_W-1:0] REQ_NONE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TIMED = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CONT  = 2'd2;

    // register reset values
    localparam logic [RAW_W-1:0] MIN_RAW_RST = 11'd48;
    localparam logic [RAW_W-1:0] MAX_RAW_RST = 11'd2047;

endpackage

FILE: rtl/qxmm_tick_if.sv
`timescale 1ns / 1ps
// control tick channel: throttle, pitch, roll, yaw and millisecond time
// depends on qxmm_pkg

interface qxmm_tick_if import qxmm_pkg::*; ;
    logic                     valid;
    logic                     ready;
    logic signed [CMD_W-1:0]  throttle_cmd;
    logic signed [CMD_W-1:0]  pitch_cmd;
    logic signed [CMD_W-1:0]  roll_cmd;
    logic signed [CMD_W-1:0]  yaw_cmd;
    logic [TIME_W-1:0]        now_ms;

    modport source (
        output valid, throttle_cmd, pitch_cmd, roll_cmd, yaw_cmd, now_ms,
        input  ready
    );
    modport sink (
        input  valid, throttle_cmd, pitch_cmd, roll_cmd, yaw_cmd, now_ms,
        output ready
    );
endinterface

FILE: rtl/qxmm_motor_if.sv
`timescale 1ns / 1ps
// motor command channel: four raw commands and the test flag
// depends on qxmm_pkg

interface qxmm_motor_if import qxmm_pkg::*; ;
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] motor_0;
    logic [RAW_W-1:0] motor_1;
    logic [RAW_W-1:0] motor_2;
    logic [RAW_W-1:0] motor_3;
    logic             testing;

    modport source (
        output valid, motor_0, motor_1, motor_2, motor_3, testing,
        input  ready
    );
    modport sink (
        input  valid, motor_0, motor_1, motor_2, motor_3, testing,
        output ready
    );
endinterface

FILE: rtl/quad_x_motor_mixer_with_test.sv
`timescale 1ns / 1ps
// quad-x motor mixer with motor test mode, top level
// depends on qxmm_pkg, qxmm_tick_if, qxmm_motor_if
//
//  channel   | direction | handshake      | payload
//  i_tick    | in        | valid / ready  | throttle, pitch, roll, yaw (Q2.14), now_ms
//  o_mix     | out       | valid / ready  | motor_0..motor_3 (raw), testing
//  i_cfg_*   | in        | write enable   | index, 32-bit data, no read-back
//
// one tick per cycle while the output is not stalled; each tick passes the input register, then the result register
// the mixing, scaling and clamping sit between the two registers in one pass
// i_rst_n is synchronous and active low; it loads the register defaults and idles the test
// a stalled output holds its result; the input register keeps accepting while
// the result register is free or being drained in the same cycle

module quad_x_motor_mixer_with_test
    import qxmm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    qxmm_tick_if.sink             i_tick,
    qxmm_motor_if.source          o_mix
);

    // arithmetic widths
    localparam int MW = CMD_W + 2;
    localparam int DW = RAW_W + 1;
    localparam int PW = MW + DW;
    localparam int LW = RAW_W + 1 + FRAC_BITS;
    localparam int XW = ((PW > LW) ? PW : LW) + 1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_TIMED = 2'd1,
        PH_CONT  = 2'd2
    } t_test_phase;

    typedef logic [RAW_W-1:0] t_raw;

    // configuration registers
    t_raw                     r_min_raw;
    t_raw                     r_max_raw;
    logic signed [CMD_W-1:0]  r_deadzone;
    logic [SLOT_W-1:0]        r_test_motor;
    logic [LEVEL_W-1:0]       r_test_level;
    logic [TIME_W-1:0]        r_test_dur;

    // test state
    t_test_phase              r_test_phase;
    logic [TIME_W-1:0]        r_start_time;
    logic                     r_start_latched;

    // input register
    logic                     r_in_valid;
    logic signed [CMD_W-1:0]  r_thr;
    logic signed [CMD_W-1:0]  r_pitch;
    logic signed [CMD_W-1:0]  r_roll;
    logic signed [CMD_W-1:0]  r_yaw;
    logic [TIME_W-1:0]        r_now;

    // result register
    logic                     r_out_valid;
    t_raw                     r_motor [MOTOR_CNT];
    logic                     r_testing;

    // next values
    t_raw                     n_motor [MOTOR_CNT];
    logic                     n_testing;
    t_test_phase              n_test_phase;
    logic [TIME_W-1:0]        n_start_time;
    logic                     n_start_latched;

    logic                     out_adv;
    logic                     s1_adv;
    logic                     in_xfer;

    logic signed [MW-1:0]     t_e, p_e, r_e, y_e;
    logic signed [MW-1:0]     mix [MOTOR_CNT];
    t_raw                     mix_raw [MOTOR_CNT];
    t_raw                     test_raw;
    logic [TIME_W-1:0]        start_eff;
    logic [TIME_W-1:0]        elapsed;
    logic                     test_stop;
    t_test_phase              req_phase;

    // scale a normalized value into min..max and clamp it
    function automatic t_raw f_scale(
        input logic signed [MW-1:0] m,
        input t_raw                 lo_raw,
        input t_raw                 hi_raw
    );
        logic signed [DW-1:0] diff;
        logic signed [PW-1:0] prod;
        logic signed [XW-1:0] lo;
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] x;
        diff = $signed({1'b0, hi_raw}) - $signed({1'b0, lo_raw});
        prod = m * diff;
        lo   = $signed(XW'({1'b0, lo_raw})) <<< FRAC_BITS;
        hi   = $signed(XW'({1'b0, hi_raw})) <<< FRAC_BITS;
        x    = lo + XW'(prod);
        if (x < lo) begin
            f_scale = lo_raw;
        end else if (x > hi) begin
            f_scale = hi_raw;
        end else begin
            f_scale = x[FRAC_BITS +: RAW_W];
        end
    endfunction

    // handshakes
    assign out_adv      = !r_out_valid || o_mix.ready;
    assign s1_adv       = r_in_valid && out_adv;
    assign i_tick.ready = !r_in_valid || out_adv;
    assign in_xfer      = i_tick.valid && i_tick.ready;

    // mixing sums
    always_comb begin
        t_e = MW'(r_thr);
        p_e = MW'(r_pitch);
        r_e = MW'(r_roll);
        y_e = MW'(r_yaw);
        mix[0] = t_e - p_e + r_e - y_e;
        mix[1] = t_e - p_e - r_e + y_e;
        mix[2] = t_e + p_e + r_e + y_e;
        mix[3] = t_e + p_e - r_e - y_e;
        for (int i = 0; i < MOTOR_CNT; i++) begin
            mix_raw[i] = f_scale(mix[i], r_min_raw, r_max_raw);
        end
        test_raw = f_scale($signed(MW'({1'b0, r_test_level})), r_min_raw, r_max_raw);
    end

    // timed test check
    assign start_eff = r_start_latched ? r_start_time : r_now;
    assign elapsed   = r_now - start_eff;
    assign test_stop = (r_test_phase == PH_TIMED) && (elapsed >= r_test_dur);

    // result and test state for the item in the input register
    always_comb begin
        n_testing       = 1'b0;
        n_test_phase    = r_test_phase;
        n_start_time    = r_start_time;
        n_start_latched = r_start_latched;
        for (int i = 0; i < MOTOR_CNT; i++) begin
            n_motor[i] = '0;
        end
        if (r_test_phase == PH_TIMED || r_test_phase == PH_CONT) begin
            n_testing = 1'b1;
            if (test_stop) begin
                n_test_phase    = PH_IDLE;
                n_start_time    = '0;
                n_start_latched = 1'b0;
            end else begin
                if (r_test_phase == PH_TIMED && !r_start_latched) begin
                    n_start_time    = r_now;
                    n_start_latched = 1'b1;
                end
                for (int i = 0; i < MOTOR_CNT; i++) begin
                    if (r_test_motor == SLOT_W'(i)) begin
                        n_motor[i] = test_raw;
                    end
                end
            end
        end else if (r_thr >= r_deadzone) begin
            for (int i = 0; i < MOTOR_CNT; i++) begin
                n_motor[i] = mix_raw[i];
            end
        end
    end

    // request code decode, code three idles the test
    always_comb begin
        unique case (i_cfg_data[REQ_W-1:0])
            REQ_TIMED: req_phase = PH_TIMED;
            REQ_CONT:  req_phase = PH_CONT;
            default:   req_phase = PH_IDLE;
        endcase
    end

    // configuration and test state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_raw       <= MIN_RAW_RST;
            r_max_raw       <= MAX_RAW_RST;
            r_deadzone      <= '0;
            r_test_motor    <= '0;
            r_test_level    <= '0;
            r_test_dur      <= '0;
            r_test_phase    <= PH_IDLE;
            r_start_time    <= '0;
            r_start_latched <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_RAW:    r_min_raw    <= i_cfg_data[RAW_W-1:0];
                CFG_MAX_RAW:    r_max_raw    <= i_cfg_data[RAW_W-1:0];
                CFG_DEADZONE:   r_deadzone   <= $signed(i_cfg_data[CMD_W-1:0]);
                CFG_TEST_REQ: begin
                    r_test_phase    <= req_phase;
                    r_start_time    <= '0;
                    r_start_latched <= 1'b0;
                end
                CFG_TEST_MOTOR: r_test_motor <= i_cfg_data[SLOT_W-1:0];
                CFG_TEST_LEVEL: r_test_level <= i_cfg_data[LEVEL_W-1:0];
                CFG_TEST_DUR:   r_test_dur   <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end else if (s1_adv) begin
            r_test_phase    <= n_test_phase;
            r_start_time    <= n_start_time;
            r_start_latched <= n_start_latched;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_tick.ready) begin
            r_in_valid <= i_tick.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_thr   <= i_tick.throttle_cmd;
            r_pitch <= i_tick.pitch_cmd;
            r_roll  <= i_tick.roll_cmd;
            r_yaw   <= i_tick.yaw_cmd;
            r_now   <= i_tick.now_ms;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_motor   <= n_motor;
            r_testing <= n_testing;
        end
    end

    assign o_mix.valid   = r_out_valid;
    assign o_mix.motor_0 = r_motor[0];
    assign o_mix.motor_1 = r_motor[1];
    assign o_mix.motor_2 = r_motor[2];
    assign o_mix.motor_3 = r_motor[3];
    assign o_mix.testing = r_testing;

    // a latched start time only exists during a timed test
    a_latch_timed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start_latched |-> (r_test_phase == PH_TIMED))
        else $error("start time latched outside a timed test");

    // arming a test always restarts the timer
    a_arm_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_idx == CFG_TEST_REQ) |=> !r_start_latched)
        else $error("test arming did not clear the start latch");

    // a test result drives at most one motor
    a_test_one_motor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mix.valid && o_mix.testing) |->
            ($countones({o_mix.motor_0 != '0, o_mix.motor_1 != '0,
                         o_mix.motor_2 != '0, o_mix.motor_3 != '0}) <= 1))
        else $error("more than one motor driven in test mode");

    // an accepted tick lands in the input register
    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tick.valid && i_tick.ready) |=> r_in_valid)
        else $error("accepted tick lost at the input register");

endmodule

FILE: bench/tb_quad_x_motor_mixer_with_test.sv
`timescale 1ns / 1ps
// self-checking bench for the quad-x motor mixer: random and directed ticks, random stalls
// predicts the motor commands in-bench; depends on qxmm_pkg, qxmm_tick_if, qxmm_motor_if

module tb_quad_x_motor_mixer_with_test;
    import qxmm_pkg::*;

    // request code three, treated as none by the block
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int FRAC = FRAC_BITS_DEF;
    localparam int ITEM_TARGET = 500;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [CMD_W-1:0]  thr;
        logic [CMD_W-1:0]  pitch;
        logic [CMD_W-1:0]  roll;
        logic [CMD_W-1:0]  yaw;
        logic [TIME_W-1:0] now;
    } t_tick;

    typedef struct packed {
        logic [MOTOR_CNT-1:0][RAW_W-1:0] motor;
        logic                            testing;
    } t_motor_cmd;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    qxmm_tick_if  tick ();
    qxmm_motor_if mix ();

    quad_x_motor_mixer_with_test u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_tick     (tick),
        .o_mix      (mix)
    );

    always #5 i_clk = ~i_clk;

    // bench copy of registers and test state
    logic [RAW_W-1:0]        min_raw_q   = MIN_RAW_RST;
    logic [RAW_W-1:0]        max_raw_q   = MAX_RAW_RST;
    logic signed [CMD_W-1:0] deadzone_q  = '0;
    logic [SLOT_W-1:0]       test_slot_q = '0;
    logic [LEVEL_W-1:0]      test_lvl_q  = '0;
    logic [TIME_W-1:0]       test_dur_q  = '0;
    logic [REQ_W-1:0]        test_phase  = REQ_NONE;
    logic [TIME_W-1:0]       start_ms    = '0;
    logic                    start_held  = 1'b0;

    t_tick      pending_ticks[$];
    t_motor_cmd expected_cmds[$];

    int         errors     = 0;
    int         cycles     = 0;
    int         items_sent = 0;
    int         send_gap   = 0;
    int         take_gap   = 0;
    bit         stalls_on  = 1'b0;
    logic       tick_fire  = 1'b0;
    logic [TIME_W-1:0] clock_ms = '0;
    t_tick      next_tick;
    t_tick      seen_tick;
    t_motor_cmd got, want;

    // gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // scale a Q2.14 value into the raw range and clamp it
    function automatic logic [RAW_W-1:0] to_raw(longint m);
        longint lo, hi, x;
        lo = longint'(min_raw_q) <<< FRAC;
        hi = longint'(max_raw_q) <<< FRAC;
        x  = lo + m * (longint'(max_raw_q) - longint'(min_raw_q));
        if (x < lo) x = lo;
        else if (x > hi) x = hi;
        return x[FRAC+RAW_W-1:FRAC];
    endfunction

    // motor commands for one tick, advancing the test state
    function automatic t_motor_cmd predict_motors(t_tick k);
        t_motor_cmd r;
        longint t, p, rl, y;
        logic [TIME_W-1:0] since;
        r  = '0;
        t  = longint'($signed(k.thr));
        p  = longint'($signed(k.pitch));
        rl = longint'($signed(k.roll));
        y  = longint'($signed(k.yaw));
        if (test_phase == REQ_TIMED || test_phase == REQ_CONT) begin
            r.testing = 1'b1;
            if (test_phase == REQ_TIMED) begin
                if (!start_held) begin
                    start_ms   = k.now;
                    start_held = 1'b1;
                end
                since = k.now - start_ms;
                if (since >= test_dur_q) begin
                    test_phase = REQ_NONE;
                    start_ms   = '0;
                    start_held = 1'b0;
                    return r;
                end
            end
            r.motor[test_slot_q] = to_raw(longint'(test_lvl_q));
            return r;
        end
        if ($signed(k.thr) < deadzone_q) return r;
        r.motor[0] = to_raw(t - p + rl - y);
        r.motor[1] = to_raw(t - p - rl + y);
        r.motor[2] = to_raw(t + p + rl + y);
        r.motor[3] = to_raw(t + p - rl - y);
        return r;
    endfunction

    // register write, mirrored into the bench state
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_MIN_RAW:    min_raw_q = val[RAW_W-1:0];
            CFG_MAX_RAW:    max_raw_q = val[RAW_W-1:0];
            CFG_DEADZONE:   deadzone_q = val[CMD_W-1:0];
            CFG_TEST_REQ: begin
                test_phase = (val[REQ_W-1:0] == REQ_UNUSED) ? REQ_NONE : val[REQ_W-1:0];
                start_held = 1'b0;
                start_ms   = '0;
            end
            CFG_TEST_MOTOR: test_slot_q = val[SLOT_W-1:0];
            CFG_TEST_LEVEL: test_lvl_q = val[LEVEL_W-1:0];
            CFG_TEST_DUR:   test_dur_q = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_tick(input logic [CMD_W-1:0] t, input logic [CMD_W-1:0] p,
                             input logic [CMD_W-1:0] r, input logic [CMD_W-1:0] y,
                             input logic [TIME_W-1:0] now);
        t_tick k;
        k.thr   = t;
        k.pitch = p;
        k.roll  = r;
        k.yaw   = y;
        k.now   = now;
        pending_ticks.push_back(k);
        items_sent++;
    endtask

    // random ticks: mostly flight-like commands on a running clock, some noise
    task automatic add_random(input int n);
        int i, dp, dr, dy;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
            else clock_ms = clock_ms + $urandom_range(0, 4);
            if ($urandom_range(0, 9) < 7) begin
                dp = int'($urandom_range(0, 8192)) - 4096;
                dr = int'($urandom_range(0, 8192)) - 4096;
                dy = int'($urandom_range(0, 8192)) - 4096;
                push_tick(CMD_W'($urandom_range(0, 17000)), dp[CMD_W-1:0], dr[CMD_W-1:0],
                          dy[CMD_W-1:0], clock_ms);
            end else begin
                push_tick(CMD_W'($urandom), CMD_W'($urandom), CMD_W'($urandom),
                          CMD_W'($urandom), clock_ms);
            end
        end
    endtask

    // wait until every tick went out and every command came back
    task automatic drain();
        while (pending_ticks.size() != 0 || tick.valid || expected_cmds.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(input int n, input bit stalls);
        stalls_on = stalls;
        add_random(n);
        drain();
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_raw();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 2047;
            default: return $urandom_range(0, 2047);
        endcase
    endfunction

    // prediction on tick transfer, checking on command transfer
    always @(posedge i_clk) begin
        tick_fire <= i_rst_n && tick.valid && tick.ready;
        if (i_rst_n && tick.valid && tick.ready) begin
            seen_tick.thr   = tick.throttle_cmd;
            seen_tick.pitch = tick.pitch_cmd;
            seen_tick.roll  = tick.roll_cmd;
            seen_tick.yaw   = tick.yaw_cmd;
            seen_tick.now   = tick.now_ms;
            expected_cmds.push_back(predict_motors(seen_tick));
        end
        if (i_rst_n && mix.valid && mix.ready) begin
            got.motor   = {mix.motor_3, mix.motor_2, mix.motor_1, mix.motor_0};
            got.testing = mix.testing;
            if (expected_cmds.size() == 0) begin
                $display("%0t: unexpected command transfer, expected none, got %h",
                         $time, got);
                errors++;
            end else begin
                want = expected_cmds.pop_front();
                for (int m = 0; m < MOTOR_CNT; m++) begin
                    if (got.motor[m] !== want.motor[m]) begin
                        $display("%0t: motor_%0d expected %0d, got %0d",
                                 $time, m, want.motor[m], got.motor[m]);
                        errors++;
                    end
                end
                if (got.testing !== want.testing) begin
                    $display("%0t: testing expected %0d, got %0d",
                             $time, want.testing, got.testing);
                    errors++;
                end
            end
        end
    end

    // tick driver, fed from the pending queue
    always @(negedge i_clk) begin
        if (i_rst_n && (!tick.valid || tick_fire)) begin
            if (send_gap > 0) begin
                tick.valid <= 1'b0;
                send_gap = send_gap - 1;
            end else if (pending_ticks.size() > 0) begin
                next_tick = pending_ticks.pop_front();
                tick.valid        <= 1'b1;
                tick.throttle_cmd <= next_tick.thr;
                tick.pitch_cmd    <= next_tick.pitch;
                tick.roll_cmd     <= next_tick.roll;
                tick.yaw_cmd      <= next_tick.yaw;
                tick.now_ms       <= next_tick.now;
                send_gap = stalls_on ? pick_gap() : 0;
            end else begin
                tick.valid <= 1'b0;
            end
        end
    end

    // output stalls
    always @(negedge i_clk) begin
        if (take_gap > 0) begin
            mix.ready <= 1'b0;
            take_gap = take_gap - 1;
        end else begin
            mix.ready <= 1'b1;
            take_gap = stalls_on ? pick_gap() : 0;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_MIN_RAW;
        cfg_data          = '0;
        tick.valid        = 1'b0;
        tick.throttle_cmd = '0;
        tick.pitch_cmd    = '0;
        tick.roll_cmd     = '0;
        tick.yaw_cmd      = '0;
        tick.now_ms       = '0;
        mix.ready         = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: field extremes and mixing corners at reset settings
        stalls_on = 1'b1;
        push_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
        push_tick(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
        push_tick(16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h0000_0001);
        push_tick(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 32'h8000_0000);
        push_tick(16'h4000, 16'h0000, 16'h0000, 16'h0000, 32'h7FFF_FFFF);
        push_tick(16'h2000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0002);
        push_tick(16'h2000, 16'h7FFF, 16'h0000, 16'h0000, 32'h0000_0003);
        push_tick(16'h2000, 16'h8000, 16'h0000, 16'h0000, 32'h0000_0004);
        push_tick(16'h2000, 16'h0000, 16'h7FFF, 16'h0000, 32'h0000_0005);
        push_tick(16'h2000, 16'h0000, 16'h8000, 16'h0000, 32'h0000_0006);
        push_tick(16'h2000, 16'h0000, 16'h0000, 16'h7FFF, 32'h0000_0007);
        push_tick(16'h2000, 16'h0000, 16'h0000, 16'h8000, 32'h0000_0008);
        push_tick(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h5555_5555);
        push_tick(16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 32'hAAAA_AAAA);
        push_tick(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 32'h0000_0009);
        push_tick(16'h0000, 16'h1000, 16'hF000, 16'h0800, 32'h0000_000A);
        drain();

        // wide range, deadzone at the bottom, no stalls
        write_reg(CFG_MIN_RAW, 0);
        write_reg(CFG_MAX_RAW, 2047);
        write_reg(CFG_DEADZONE, 32'h0000_8000);
        run_phase(30, 1'b0);

        // inverted limits, then equal limits
        write_reg(CFG_MIN_RAW, 2047);
        write_reg(CFG_MAX_RAW, 0);
        run_phase(25, 1'b1);
        write_reg(CFG_MIN_RAW, 1000);
        write_reg(CFG_MAX_RAW, 1000);
        run_phase(15, 1'b1);

        // deadzone at the top, narrow range
        write_reg(CFG_MAX_RAW, 1100);
        write_reg(CFG_DEADZONE, 32'h0000_7FFF);
        run_phase(20, 1'b1);

        // continuous test at full level, then above full level, then stopped
        write_reg(CFG_MIN_RAW, 48);
        write_reg(CFG_MAX_RAW, 2047);
        write_reg(CFG_DEADZONE, 0);
        write_reg(CFG_TEST_MOTOR, 3);
        write_reg(CFG_TEST_LEVEL, 16384);
        write_reg(CFG_TEST_REQ, CFG_DATA_W'(REQ_CONT));
        run_phase(15, 1'b1);
        write_reg(CFG_TEST_MOTOR, 1);
        write_reg(CFG_TEST_LEVEL, 32'h0000_7FFF);
        run_phase(10, 1'b1);
        write_reg(CFG_TEST_REQ, CFG_DATA_W'(REQ_NONE));
        run_phase(10, 1'b1);

        // timed test across the time wrap, ending mid-phase
        clock_ms = 32'hFFFF_FFF0;
        write_reg(CFG_TEST_MOTOR, 2);
        write_reg(CFG_TEST_LEVEL, 5000);
        write_reg(CFG_TEST_DUR, 12);
        write_reg(CFG_TEST_REQ, CFG_DATA_W'(REQ_TIMED));
        run_phase(30, 1'b1);

        // zero duration stops on the first tick
        write_reg(CFG_TEST_DUR, 0);
        write_reg(CFG_TEST_REQ, CFG_DATA_W'(REQ_TIMED));
        run_phase(10, 1'b1);

        // request code three idles the test
        write_reg(CFG_TEST_DUR, 32'hFFFF_FFFF);
        write_reg(CFG_TEST_REQ, CFG_DATA_W'(REQ_TIMED));
        write_reg(CFG_TEST_REQ, CFG_DATA_W'(REQ_UNUSED));
        run_phase(10, 1'b1);

        // longest duration, then a silent stop
        write_reg(CFG_TEST_MOTOR, 0);
        write_reg(CFG_TEST_LEVEL, 0);
        write_reg(CFG_TEST_REQ, CFG_DATA_W'(REQ_TIMED));
        run_phase(10, 1'b1);
        write_reg(CFG_TEST_REQ, CFG_DATA_W'(REQ_NONE));

        // random settings per phase
        while (items_sent < ITEM_TARGET) begin
            write_reg(CFG_MIN_RAW, pick_raw());
            write_reg(CFG_MAX_RAW, pick_raw());
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_DEADZONE, $urandom);
            else
                write_reg(CFG_DEADZONE, $urandom_range(0, 4000) - 2000);
            write_reg(CFG_TEST_MOTOR, $urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0: write_reg(CFG_TEST_LEVEL, 0);
                1: write_reg(CFG_TEST_LEVEL, 16384);
                2: write_reg(CFG_TEST_LEVEL, 32'h0000_7FFF);
                default: write_reg(CFG_TEST_LEVEL, $urandom_range(0, 16384));
            endcase
            case ($urandom_range(0, 3))
                0: write_reg(CFG_TEST_DUR, 0);
                1: write_reg(CFG_TEST_DUR, 32'hFFFF_FFFF);
                2: write_reg(CFG_TEST_DUR, $urandom);
                default: write_reg(CFG_TEST_DUR, $urandom_range(1, 60));
            endcase
            case ($urandom_range(0, 5))
                3: write_reg(CFG_TEST_REQ, CFG_DATA_W'(REQ_TIMED));
                4: write_reg(CFG_TEST_REQ, CFG_DATA_W'(REQ_CONT));
                5: write_reg(CFG_TEST_REQ, CFG_DATA_W'(REQ_UNUSED));
                default: write_reg(CFG_TEST_REQ, CFG_DATA_W'(REQ_NONE));
            endcase
            run_phase($urandom_range(15, 50), $urandom_range(0, 3) != 0);
        end

        repeat (6) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/qxmm_pkg.sv
rtl/qxmm_tick_if.sv
rtl/qxmm_motor_if.sv
rtl/quad_x_motor_mixer_with_test.sv
bench/tb_quad_x_motor_mixer_with_test.sv
